[sv/bfa_pkg.sv]
package bfa_pkg;

   localparam int MEM_WORDS        = 1024;
   localparam int DEF_FREE_ENTRIES = 64;
   localparam int DEF_USED_ENTRIES = 64;
   localparam int WORD_W           = 11;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [2:0]        status_type;
   typedef logic [2:0]        fop_type;
   typedef logic [1:0]        bsel_type;
   typedef logic [1:0]        isrc_type;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam status_type ST_OK       = 3'd0;
   localparam status_type ST_NOFIT    = 3'd1;
   localparam status_type ST_NOTFOUND = 3'd2;
   localparam status_type ST_FULL     = 3'd3;
   localparam status_type ST_ZERO     = 3'd4;

   // free table write operations
   localparam fop_type FOP_SHRINK = 3'd0;
   localparam fop_type FOP_BOTH   = 3'd1;
   localparam fop_type FOP_PRE    = 3'd2;
   localparam fop_type FOP_POST   = 3'd3;
   localparam fop_type FOP_APPEND = 3'd4;
   localparam fop_type FOP_DROP   = 3'd5;

   // used table write operations
   localparam logic UOP_RECORD = 1'b0;
   localparam logic UOP_DROP   = 1'b1;

   // result base address source
   localparam bsel_type BSEL_ZERO = 2'd0;
   localparam bsel_type BSEL_BEST = 2'd1;
   localparam bsel_type BSEL_ADDR = 2'd2;

   // index load source
   localparam isrc_type ISRC_BEST = 2'd0;
   localparam isrc_type ISRC_REC  = 2'd1;
   localparam isrc_type ISRC_POST = 2'd2;

   typedef struct packed {
      logic       ld_req;
      logic       idx_clr;
      logic       idx_inc;
      logic       idx_ld;
      isrc_type   idx_src;
      logic       rd_next;
      logic       best_upd;
      logic       rec_upd;
      logic       pre_upd;
      logic       post_upd;
      logic       fwr;
      fop_type    fop;
      logic       uwr;
      logic       uop;
      logic       fc_inc;
      logic       fc_dec;
      logic       uc_inc;
      logic       uc_dec;
      logic       res_ld;
      status_type res_status;
      bsel_type   res_bsel;
      logic       out_ld;
   } cmd_type;

   typedef struct packed {
      logic cmd_free;
      logic size_zero;
      logic used_full;
      logic used_empty;
      logic free_empty;
      logic free_full;
      logic fit;
      logic better;
      logic exact;
      logic free_last;
      logic used_last;
      logic u_hit;
      logic f_pre;
      logic f_post;
      logic found;
      logic has_pre;
      logic has_post;
      logic best_empty;
      logic out_busy;
   } sts_type;

endpackage

[sv/bfa_if.sv]
interface bfa_req_if import bfa_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     cmd;
   word_type req_size;
   word_type req_addr;

   modport source (output valid, output cmd, output req_size, output req_addr, input ready);
   modport sink (input valid, input cmd, input req_size, input req_addr, output ready);
endinterface

interface bfa_rsp_if import bfa_pkg::*; ();
   logic       valid;
   logic       ready;
   word_type   base_addr;
   status_type status;

   modport source (output valid, output base_addr, output status, input ready);
   modport sink (input valid, input base_addr, input status, output ready);
endinterface

[sv/bfa_dp.sv]
module bfa_dp import bfa_pkg::*; #(
   parameter int FREE_ENTRIES = DEF_FREE_ENTRIES,
   parameter int USED_ENTRIES = DEF_USED_ENTRIES
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_cmd,
   input  word_type   req_size,
   input  word_type   req_addr,
   input  cmd_type    cmd,
   output sts_type    sts,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   output word_type   rsp_base_addr,
   output status_type rsp_status
);

   localparam int FIW = $clog2(FREE_ENTRIES);
   localparam int UIW = $clog2(USED_ENTRIES);
   localparam int IW  = (FIW > UIW) ? FIW : UIW;
   localparam int NW  = IW + 1;
   localparam int FCW = $clog2(FREE_ENTRIES + 1);
   localparam int UCW = $clog2(USED_ENTRIES + 1);
   localparam int EW  = 2 * WORD_W;

   logic [EW-1:0] free_mem [FREE_ENTRIES];
   logic [EW-1:0] used_mem [USED_ENTRIES];

   logic           cmd_ff;
   word_type       size_ff, addr_ff;
   logic [IW-1:0]  idx_ff;
   logic [FCW-1:0] fc_ff;
   logic [UCW-1:0] uc_ff;
   logic [FIW-1:0] best_idx_ff, pre_idx_ff, post_idx_ff;
   word_type       best_start_ff, best_left_ff;
   logic           found_ff, has_pre_ff, has_post_ff;
   logic [UIW-1:0] rec_ff;
   word_type       pre_start_ff, pre_len_ff, post_start_ff, post_len_ff;
   word_type       res_base_ff, out_base_ff;
   status_type     res_status_ff, out_status_ff;
   logic           out_valid_ff;
   logic [EW-1:0]  f_rdata_ff, u_rdata_ff;

   logic [IW-1:0]  idx_rd;
   logic [NW-1:0]  idx_nx;
   word_type       f_start, f_len, u_start, u_len, left;
   logic [FIW-1:0] f_waddr;
   logic [EW-1:0]  f_wdata;
   logic [UIW-1:0] u_waddr;
   logic [EW-1:0]  u_wdata;
   word_type       base_sel;

   assign idx_rd  = cmd.rd_next ? idx_ff + 1'b1 : idx_ff;
   assign idx_nx  = {1'b0, idx_ff} + 1'b1;
   assign f_start = f_rdata_ff[EW-1:WORD_W];
   assign f_len   = f_rdata_ff[WORD_W-1:0];
   assign u_start = u_rdata_ff[EW-1:WORD_W];
   assign u_len   = u_rdata_ff[WORD_W-1:0];
   assign left    = f_len - size_ff;

   // table memories, registered read
   always_ff @(posedge clock) begin
      f_rdata_ff <= free_mem[idx_rd[FIW-1:0]];
      u_rdata_ff <= used_mem[idx_rd[UIW-1:0]];
      if (reset) begin
         free_mem[0] <= {word_type'(1), word_type'(MEM_WORDS)};
      end else if (cmd.fwr) begin
         free_mem[f_waddr] <= f_wdata;
      end
      if (cmd.uwr) begin
         used_mem[u_waddr] <= u_wdata;
      end
   end

   always_comb begin
      case (cmd.fop)
         FOP_SHRINK: begin
            f_waddr = best_idx_ff;
            f_wdata = {best_start_ff + size_ff, best_left_ff};
         end
         FOP_BOTH: begin
            f_waddr = pre_idx_ff;
            f_wdata = {pre_start_ff, pre_len_ff + size_ff + post_len_ff};
         end
         FOP_PRE: begin
            f_waddr = pre_idx_ff;
            f_wdata = {pre_start_ff, pre_len_ff + size_ff};
         end
         FOP_POST: begin
            f_waddr = post_idx_ff;
            f_wdata = {post_start_ff - size_ff, post_len_ff + size_ff};
         end
         FOP_APPEND: begin
            f_waddr = fc_ff[FIW-1:0];
            f_wdata = {addr_ff, size_ff};
         end
         default: begin
            f_waddr = idx_ff[FIW-1:0];
            f_wdata = f_rdata_ff;
         end
      endcase
      if (cmd.uop == UOP_RECORD) begin
         u_waddr = uc_ff[UIW-1:0];
         u_wdata = {best_start_ff, size_ff};
      end else begin
         u_waddr = idx_ff[UIW-1:0];
         u_wdata = u_rdata_ff;
      end
      case (cmd.res_bsel)
         BSEL_BEST: base_sel = best_start_ff;
         BSEL_ADDR: base_sel = addr_ff;
         default:   base_sel = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.ld_req) begin
         cmd_ff  <= req_cmd;
         size_ff <= req_size;
         addr_ff <= req_addr;
      end else if (cmd.rec_upd) begin
         size_ff <= u_len;
      end
      if (cmd.best_upd) begin
         best_idx_ff   <= idx_ff[FIW-1:0];
         best_start_ff <= f_start;
         best_left_ff  <= left;
      end
      if (cmd.rec_upd) begin
         rec_ff <= idx_ff[UIW-1:0];
      end
      if (cmd.pre_upd) begin
         pre_idx_ff   <= idx_ff[FIW-1:0];
         pre_start_ff <= f_start;
         pre_len_ff   <= f_len;
      end
      if (cmd.post_upd) begin
         post_idx_ff   <= idx_ff[FIW-1:0];
         post_start_ff <= f_start;
         post_len_ff   <= f_len;
      end
      if (cmd.res_ld) begin
         res_base_ff   <= base_sel;
         res_status_ff <= cmd.res_status;
      end
      if (cmd.out_ld) begin
         out_base_ff   <= res_base_ff;
         out_status_ff <= res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         fc_ff        <= FCW'(1);
         uc_ff        <= '0;
         found_ff     <= 1'b0;
         has_pre_ff   <= 1'b0;
         has_post_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.idx_clr) begin
            idx_ff <= '0;
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_ff + 1'b1;
         end else if (cmd.idx_ld) begin
            case (cmd.idx_src)
               ISRC_REC:  idx_ff <= IW'(rec_ff);
               ISRC_POST: idx_ff <= IW'(post_idx_ff);
               default:   idx_ff <= IW'(best_idx_ff);
            endcase
         end
         if (cmd.fc_inc) begin
            fc_ff <= fc_ff + 1'b1;
         end else if (cmd.fc_dec) begin
            fc_ff <= fc_ff - 1'b1;
         end
         if (cmd.uc_inc) begin
            uc_ff <= uc_ff + 1'b1;
         end else if (cmd.uc_dec) begin
            uc_ff <= uc_ff - 1'b1;
         end
         if (cmd.ld_req) begin
            found_ff    <= 1'b0;
            has_pre_ff  <= 1'b0;
            has_post_ff <= 1'b0;
         end else begin
            if (cmd.best_upd) found_ff    <= 1'b1;
            if (cmd.pre_upd)  has_pre_ff  <= 1'b1;
            if (cmd.post_upd) has_post_ff <= 1'b1;
         end
         if (cmd.out_ld) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      sts.cmd_free   = (cmd_ff == CMD_FREE);
      sts.size_zero  = (size_ff == '0);
      sts.used_full  = (uc_ff == UCW'(USED_ENTRIES));
      sts.used_empty = (uc_ff == '0);
      sts.free_empty = (fc_ff == '0);
      sts.free_full  = (fc_ff == FCW'(FREE_ENTRIES));
      sts.fit        = (f_len >= size_ff);
      sts.better     = !found_ff || (left < best_left_ff);
      sts.exact      = (left == '0);
      sts.free_last  = (idx_nx >= NW'(fc_ff));
      sts.used_last  = (idx_nx >= NW'(uc_ff));
      sts.u_hit      = (u_start == addr_ff);
      sts.f_pre      = ({1'b0, f_start} + {1'b0, f_len}) == {1'b0, addr_ff};
      sts.f_post     = {1'b0, f_start} == ({1'b0, addr_ff} + {1'b0, size_ff});
      sts.found      = found_ff;
      sts.has_pre    = has_pre_ff;
      sts.has_post   = has_post_ff;
      sts.best_empty = (best_left_ff == '0);
      sts.out_busy   = out_valid_ff && !rsp_ready;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_base_addr = out_base_ff;
   assign rsp_status    = out_status_ff;

endmodule

[sv/bfa_ctrl.sv]
module bfa_ctrl import bfa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CHECK  = 4'd1;
   localparam logic [3:0] S_A_RD   = 4'd2;
   localparam logic [3:0] S_A_EV   = 4'd3;
   localparam logic [3:0] S_A_UPD  = 4'd4;
   localparam logic [3:0] S_U_RD   = 4'd5;
   localparam logic [3:0] S_U_EV   = 4'd6;
   localparam logic [3:0] S_F_RD   = 4'd7;
   localparam logic [3:0] S_F_EV   = 4'd8;
   localparam logic [3:0] S_F_DEC  = 4'd9;
   localparam logic [3:0] S_MERGE  = 4'd10;
   localparam logic [3:0] S_D_CHK  = 4'd11;
   localparam logic [3:0] S_D_WR   = 4'd12;
   localparam logic [3:0] S_FINISH = 4'd13;

   logic [3:0] state_ff, state_in;
   logic [3:0] ret_ff, ret_in;
   logic       tsel_ff, tsel_in;   // high: drop from the free table

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_FINISH;
         tsel_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         tsel_ff  <= tsel_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      tsel_in  = tsel_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.ld_req  = 1'b1;
               cmd.idx_clr = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!sts.cmd_free) begin
               if (sts.size_zero) begin
                  cmd.res_ld = 1'b1; cmd.res_status = ST_ZERO; state_in = S_FINISH;
               end else if (sts.used_full) begin
                  cmd.res_ld = 1'b1; cmd.res_status = ST_FULL; state_in = S_FINISH;
               end else if (sts.free_empty) begin
                  cmd.res_ld = 1'b1; cmd.res_status = ST_NOFIT; state_in = S_FINISH;
               end else begin
                  state_in = S_A_RD;
               end
            end else if (sts.used_empty) begin
               cmd.res_ld = 1'b1; cmd.res_status = ST_NOTFOUND; state_in = S_FINISH;
            end else begin
               state_in = S_U_RD;
            end
         end
         S_A_RD: state_in = S_A_EV;
         S_A_EV: begin
            if (sts.fit && sts.better) begin
               cmd.best_upd = 1'b1;
            end
            if (sts.fit && sts.exact) begin
               state_in = S_A_UPD;
            end else if (!sts.free_last) begin
               cmd.idx_inc = 1'b1;
               state_in    = S_A_RD;
            end else if (sts.found || sts.fit) begin
               state_in = S_A_UPD;
            end else begin
               cmd.res_ld = 1'b1; cmd.res_status = ST_NOFIT; state_in = S_FINISH;
            end
         end
         S_A_UPD: begin
            cmd.uwr        = 1'b1;
            cmd.uop        = UOP_RECORD;
            cmd.uc_inc     = 1'b1;
            cmd.res_ld     = 1'b1;
            cmd.res_status = ST_OK;
            cmd.res_bsel   = BSEL_BEST;
            if (sts.best_empty) begin
               cmd.idx_ld  = 1'b1;
               cmd.idx_src = ISRC_BEST;
               tsel_in     = 1'b1;
               ret_in      = S_FINISH;
               state_in    = S_D_CHK;
            end else begin
               cmd.fwr  = 1'b1;
               cmd.fop  = FOP_SHRINK;
               state_in = S_FINISH;
            end
         end
         S_U_RD: state_in = S_U_EV;
         S_U_EV: begin
            if (sts.u_hit) begin
               cmd.rec_upd = 1'b1;
               cmd.idx_clr = 1'b1;
               state_in    = sts.free_empty ? S_F_DEC : S_F_RD;
            end else if (!sts.used_last) begin
               cmd.idx_inc = 1'b1;
               state_in    = S_U_RD;
            end else begin
               cmd.res_ld = 1'b1; cmd.res_status = ST_NOTFOUND; state_in = S_FINISH;
            end
         end
         S_F_RD: state_in = S_F_EV;
         S_F_EV: begin
            if (sts.f_pre) begin
               cmd.pre_upd = 1'b1;
            end else if (sts.f_post) begin
               cmd.post_upd = 1'b1;
            end
            if (!sts.free_last) begin
               cmd.idx_inc = 1'b1;
               state_in    = S_F_RD;
            end else begin
               state_in = S_F_DEC;
            end
         end
         S_F_DEC: begin
            if (!sts.has_pre && !sts.has_post && sts.free_full) begin
               cmd.res_ld = 1'b1; cmd.res_status = ST_FULL; state_in = S_FINISH;
            end else begin
               cmd.idx_ld  = 1'b1;
               cmd.idx_src = ISRC_REC;
               tsel_in     = 1'b0;
               ret_in      = S_MERGE;
               state_in    = S_D_CHK;
            end
         end
         S_MERGE: begin
            cmd.res_ld     = 1'b1;
            cmd.res_status = ST_OK;
            cmd.res_bsel   = BSEL_ADDR;
            cmd.fwr        = 1'b1;
            state_in       = S_FINISH;
            if (sts.has_pre && sts.has_post) begin
               cmd.fop     = FOP_BOTH;
               cmd.idx_ld  = 1'b1;
               cmd.idx_src = ISRC_POST;
               tsel_in     = 1'b1;
               ret_in      = S_FINISH;
               state_in    = S_D_CHK;
            end else if (sts.has_pre) begin
               cmd.fop = FOP_PRE;
            end else if (sts.has_post) begin
               cmd.fop = FOP_POST;
            end else begin
               cmd.fop    = FOP_APPEND;
               cmd.fc_inc = 1'b1;
            end
         end
         S_D_CHK: begin
            if (!(tsel_ff ? sts.free_last : sts.used_last)) begin
               cmd.rd_next = 1'b1;
               state_in    = S_D_WR;
            end else begin
               cmd.fc_dec = tsel_ff;
               cmd.uc_dec = !tsel_ff;
               state_in   = ret_ff;
            end
         end
         S_D_WR: begin
            cmd.fwr     = tsel_ff;
            cmd.fop     = FOP_DROP;
            cmd.uwr     = !tsel_ff;
            cmd.uop     = UOP_DROP;
            cmd.idx_inc = 1'b1;
            state_in    = S_D_CHK;
         end
         S_FINISH: begin
            if (!sts.out_busy) begin
               cmd.out_ld = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

[sv/best_fit_allocator_unit.sv]
// best-fit allocator over words 1 to MEM_WORDS
// req_chan carries one command item: cmd selects allocate or free, req_size is
// the word count to allocate, req_addr the base to free. rsp_chan returns one
// item per command: base_addr (0 on failure) and status
// items are worked one at a time; req_chan.ready is high only while the
// controller is idle. the time per item, from the accepting cycle to the one that
// loads the output register, comes from scans and entry shifts through the
// single-port free and used tables:
//   allocate: a scan of the free extents, plus a shift of the entries behind
//             an extent that empties
//   free:     a scan of the records up to the match and of the free extents,
//             a shift of the records, plus a shift of the extents when both neighbours fuse
//   early rejections (zero size, table full, empty tables) skip the scans
// the result and req_chan.ready both appear at the edge that ends the item
// a finished item sits in an output register; a new command is taken while it
// waits, and the controller only stalls at its final step if the previous item
// is still not taken by the receiver
// reset leaves one free extent covering the whole space and no allocations,
// with no clearing pass
module best_fit_allocator_unit import bfa_pkg::*; #(
   parameter int FREE_ENTRIES = DEF_FREE_ENTRIES,
   parameter int USED_ENTRIES = DEF_USED_ENTRIES
) (
   input logic        clock,
   input logic        reset,
   bfa_req_if.sink    req_chan,
   bfa_rsp_if.source  rsp_chan
);

   // command and status bundles between controller and datapath
   cmd_type cmd;
   sts_type sts;

   bfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // tables, scan registers, counts and the output register
   bfa_dp #(
      .FREE_ENTRIES (FREE_ENTRIES),
      .USED_ENTRIES (USED_ENTRIES)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_cmd       (req_chan.cmd),
      .req_size      (req_chan.req_size),
      .req_addr      (req_chan.req_addr),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_ready     (rsp_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .rsp_base_addr (rsp_chan.base_addr),
      .rsp_status    (rsp_chan.status)
   );

endmodule

[sv/bfa_checker.sv]
module bfa_checker import bfa_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input word_type   rsp_base_addr,
   input status_type rsp_status
);

   // no item is offered straight out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_base_addr) && $stable(rsp_status))
      else $error("stalled result changed");

   // one command at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while busy");

   // success carries a real address, failures carry zero
   a_base_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= ST_ZERO) &&
                    ((rsp_status == ST_OK) == (rsp_base_addr != '0)))
      else $error("base address inconsistent with status");

endmodule

bind best_fit_allocator_unit bfa_checker u_bfa_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_base_addr (rsp_chan.base_addr),
   .rsp_status    (rsp_chan.status)
);

[test/bfa_scoreboard.sv]
package bfa_sb_pkg;

class bfa_scoreboard_type;
   // predictor state: free extents and allocation records
   bfa_pkg::word_type ext_base[$];
   bfa_pkg::word_type ext_len[$];
   bfa_pkg::word_type rec_base[$];
   bfa_pkg::word_type rec_len[$];
   bfa_pkg::word_type due_base[$];
   bfa_pkg::status_type due_status[$];
   int n_bad;
   int n_checked;

   function new();
      ext_base = '{11'd1};
      ext_len = '{bfa_pkg::word_type'(bfa_pkg::MEM_WORDS)};
      rec_base = {};
      rec_len = {};
      n_bad = 0;
      n_checked = 0;
   endfunction

   function void allocate(bfa_pkg::word_type size);
      int pick;
      int best_left;
      int left;
      pick = -1;
      best_left = 0;
      if (size == 0) begin
         due_base.push_back(0); due_status.push_back(bfa_pkg::ST_ZERO); return;
      end
      if (rec_base.size() >= bfa_pkg::DEF_USED_ENTRIES) begin
         due_base.push_back(0); due_status.push_back(bfa_pkg::ST_FULL); return;
      end
      foreach (ext_len[k]) begin
         if (ext_len[k] >= size) begin
            left = ext_len[k] - size;
            if (pick < 0 || left < best_left) begin
               pick = k; best_left = left;
            end
            if (left == 0) break;
         end
      end
      if (pick < 0) begin
         due_base.push_back(0); due_status.push_back(bfa_pkg::ST_NOFIT); return;
      end
      due_base.push_back(ext_base[pick]);
      due_status.push_back(bfa_pkg::ST_OK);
      rec_base.push_back(ext_base[pick]);
      rec_len.push_back(size);
      ext_base[pick] += size;
      ext_len[pick] -= size;
      if (ext_len[pick] == 0) begin
         ext_base.delete(pick); ext_len.delete(pick);
      end
   endfunction

   function void release_block(bfa_pkg::word_type addr);
      int rec;
      int pre;
      int post;
      bfa_pkg::word_type size;
      rec = -1; pre = -1; post = -1;
      foreach (rec_base[k]) if (rec < 0 && rec_base[k] == addr) rec = k;
      if (rec < 0) begin
         due_base.push_back(0); due_status.push_back(bfa_pkg::ST_NOTFOUND); return;
      end
      size = rec_len[rec];
      foreach (ext_base[k]) begin
         if (int'(ext_base[k]) + int'(ext_len[k]) == int'(addr)) pre = k;
         else if (int'(ext_base[k]) == int'(addr) + int'(size)) post = k;
      end
      if (pre < 0 && post < 0 && ext_base.size() >= bfa_pkg::DEF_FREE_ENTRIES) begin
         due_base.push_back(0); due_status.push_back(bfa_pkg::ST_FULL); return;
      end
      rec_base.delete(rec); rec_len.delete(rec);
      if (pre >= 0 && post >= 0) begin
         ext_len[pre] += size + ext_len[post];
         ext_base.delete(post); ext_len.delete(post);
      end else if (pre >= 0) ext_len[pre] += size;
      else if (post >= 0) begin
         ext_base[post] -= size; ext_len[post] += size;
      end else begin
         ext_base.push_back(addr); ext_len.push_back(size);
      end
      due_base.push_back(addr);
      due_status.push_back(bfa_pkg::ST_OK);
   endfunction

   function void note_command(logic cmd, bfa_pkg::word_type size, bfa_pkg::word_type addr);
      if (cmd == bfa_pkg::CMD_ALLOC) allocate(size);
      else release_block(addr);
   endfunction

   function void check_result(bfa_pkg::word_type base, bfa_pkg::status_type status);
      bfa_pkg::word_type eb;
      bfa_pkg::status_type es;
      if (due_base.size() == 0) begin
         $display("%0t: unexpected item base %0d status %0d", $time, base, status);
         n_bad++;
         return;
      end
      eb = due_base.pop_front();
      es = due_status.pop_front();
      n_checked++;
      if (base !== eb) begin
         $display("%0t: base_addr expected %0d actual %0d", $time, eb, base);
         n_bad++;
      end
      if (status !== es) begin
         $display("%0t: status expected %0d actual %0d", $time, es, status);
         n_bad++;
      end
   endfunction
endclass

endpackage

[test/tb_best_fit_allocator_unit.sv]
module tb_best_fit_allocator_unit;
   import bfa_pkg::*;
   import bfa_sb_pkg::*;

   localparam int LIMIT = 2000000;

   logic clock;
   logic reset;
   bit   quiet;
   int   cycles;
   int   n_taken;

   bfa_req_if req_chan ();
   bfa_rsp_if rsp_chan ();

   bfa_scoreboard_type sb = new();

   best_fit_allocator_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // sampling at the rising edge, plus the cycle limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("%0t: cycle limit reached, %0d items still due", $time,
                  sb.due_base.size());
         $display("simulation failed");
         $finish;
      end
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            sb.note_command(req_chan.cmd, req_chan.req_size, req_chan.req_addr);
            n_taken++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            sb.check_result(rsp_chan.base_addr, rsp_chan.status);
         end
      end
   end

   task automatic idle_gap();
      if (!quiet && $urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
   endtask

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_item(input logic c, input word_type s, input word_type a);
      idle_gap();
      req_chan.valid    = 1'b1;
      req_chan.cmd      = c;
      req_chan.req_size = s;
      req_chan.req_addr = a;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      req_chan.valid = 1'b0;
   endtask

   task automatic drain();
      while (sb.due_base.size() != 0) @(negedge clock);
   endtask

   task automatic random_item();
      int r;
      int n;
      word_type s;
      word_type a;
      r = $urandom_range(0, 99);
      n = sb.rec_base.size();
      s = word_type'($urandom_range(1, 48));
      a = word_type'($urandom_range(0, 2047));
      if (r < 5) send_item(CMD_ALLOC, '0, a);
      else if (r < 12) send_item(CMD_ALLOC, word_type'($urandom_range(900, 2047)), a);
      else if (r < 55) send_item(CMD_ALLOC, s, a);
      else if (r < 92 && n > 0) send_item(CMD_FREE, s, sb.rec_base[$urandom_range(0, n - 1)]);
      else send_item(CMD_FREE, s, a);
   endtask

   // receiver with random stalls
   initial begin : receiver
      int pause;
      rsp_chan.ready = 1'b0;
      repeat (10) @(negedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready = 1'b0;
            pause = $urandom_range(1, 15);
            while (pause > 0 && !quiet) begin
               @(negedge clock);
               pause--;
            end
         end
         rsp_chan.ready = 1'b1;
         @(negedge clock);
      end
   end

   initial begin : stimulus
      word_type held[$];
      int k;
      reset             = 1'b1;
      quiet             = 1'b0;
      req_chan.valid    = 1'b0;
      req_chan.cmd      = CMD_ALLOC;
      req_chan.req_size = '0;
      req_chan.req_addr = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // mixed traffic
      repeat (250) random_item();

      // small allocations until the record table is full
      repeat (80) send_item(CMD_ALLOC, word_type'($urandom_range(1, 3)), '0);
      drain();

      // free every other record, then some of them again, then address zero
      held = sb.rec_base;
      for (k = 0; k < held.size(); k += 2) send_item(CMD_FREE, '0, held[k]);
      for (k = 0; k < held.size(); k += 4) send_item(CMD_FREE, '0, held[k]);
      send_item(CMD_FREE, '0, '0);

      repeat (200) random_item();
      drain();

      // closing stretch with no idling on either side
      quiet = 1'b1;
      repeat (100) random_item();
      drain();
      repeat (5) @(negedge clock);

      $display("%0d commands: best and exact fits, zero sizes, no fit, full record table,",
               n_taken);
      $display("frees merging on either or both sides, unknown addresses, stalls both ways");
      if (sb.n_bad == 0 && sb.due_base.size() == 0 && sb.n_checked == n_taken) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
